// ===== src/lpgc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpgc_pkg
// Shared types, constants and helper functions of the looped pattern
// generator and checker.
// ----------------------------------------------------------------------------
package lpgc_pkg;

  // Default sizes, handed to the top level parameters
  localparam int PatternDepthDef = 1024;
  localparam int RingAddrBitsDef = 16;

  // Fixed field widths
  localparam int CfgDataW  = 17;
  localparam int CfgIdxW   = 2;
  localparam int PatLenW   = 11;
  localparam int PatIdxW   = 10;
  localparam int RingOutW  = 16;
  localparam int BlockCntW = 16;
  localparam int SeedIdxW  = 12;

  // Block size clamp: zero acts as one, anything above 65536 as 65536
  localparam logic [CfgDataW-1:0] BlockMax = 17'd65536;

  // Register reset values
  localparam logic [CfgDataW-1:0] RingBytesRst   = 17'd65536;
  localparam logic [CfgDataW-1:0] TickBytesRst   = 17'd3200;
  localparam logic [CfgDataW-1:0] PeriodBytesRst = 17'd4096;
  localparam logic [PatLenW-1:0]  PatLenRst      = 11'd7;

  // Seed pattern "abacaba"
  localparam int SeedLen = 7;
  localparam logic [7:0] SeedPattern [SeedLen] = '{8'd97, 8'd98, 8'd97, 8'd99,
                                                  8'd97, 8'd98, 8'd97};

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RING_BYTES   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TICK_BYTES   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD_BYTES = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAT_LEN      = 2'd3;

  // Request modes
  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_PLAY    = 2'd1,
    MODE_CAPTURE = 2'd2,
    MODE_RESTART = 2'd3
  } lpgc_mode_e;

  // Configuration register set
  typedef struct packed {
    logic [CfgDataW-1:0] ring_bytes;
    logic [CfgDataW-1:0] tick_bytes;
    logic [CfgDataW-1:0] period_size_bytes;
    logic [PatLenW-1:0]  pattern_length;
  } lpgc_cfg_t;

  // One input request
  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         data_in;
    logic [PatIdxW-1:0] pattern_index;
  } lpgc_item_t;

  // Front stage result, handed to the check stage
  typedef struct packed {
    logic [1:0]          mode;
    logic [7:0]          data;
    logic [RingOutW-1:0] addr;
    logic                tick_end;
    logic                period_elapsed;
  } lpgc_s1_t;

  // One output result
  typedef struct packed {
    logic [7:0]          data_out;
    logic [RingOutW-1:0] ring_address;
    logic                period_elapsed;
    logic                mismatch_flag;
    logic                tick_end;
  } lpgc_res_t;

  // Clamp a tick or period size to 1..65536
  function automatic logic [CfgDataW-1:0] block_lim(input logic [CfgDataW-1:0] v);
    logic [CfgDataW-1:0] r;
    if (v == '0) begin
      r = 17'd1;
    end else if (v > BlockMax) begin
      r = BlockMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Reset content of a pattern store entry
  function automatic logic [7:0] seed_byte(input logic [SeedIdxW-1:0] idx);
    logic [7:0] r;
    r = 8'd0;
    if (idx < SeedIdxW'(SeedLen)) begin
      r = SeedPattern[idx[2:0]];
    end
    return r;
  endfunction

endpackage

// ===== src/lpgc_if.sv =====
// ----------------------------------------------------------------------------
// lpgc_in_if / lpgc_out_if
// Valid/ready channels for input requests and output results.
// ----------------------------------------------------------------------------
interface lpgc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_in;
  logic [9:0] pattern_index;

  modport source (output valid, mode, data_in, pattern_index, input ready);
  modport sink   (input valid, mode, data_in, pattern_index, output ready);
  modport monitor (input valid, ready, mode, data_in, pattern_index);
endinterface

interface lpgc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic [15:0] ring_address;
  logic        period_elapsed;
  logic        mismatch_flag;
  logic        tick_end;

  modport source (output valid, data_out, ring_address, period_elapsed, mismatch_flag,
                  tick_end, input ready);
  modport sink   (input valid, data_out, ring_address, period_elapsed, mismatch_flag,
                  tick_end, output ready);
  modport monitor (input valid, ready, data_out, ring_address, period_elapsed,
                   mismatch_flag, tick_end);
endinterface

// ===== src/looped_pattern_generator_checker.sv =====
// ----------------------------------------------------------------------------
// looped_pattern_generator_checker
// Looped byte pattern generator and checker for a simulated ring buffer.
// A request passes through the input register, the check register and the
// output register before its result is shown.
// Throughput: one request per cycle unless stalled by the output or seeding; the
// pattern store read port is the single shared resource, one byte per cycle.
// Reset: after rst_ni the pattern store is seeded over PatternDepth cycles,
// with in_i.ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module looped_pattern_generator_checker #(
  parameter int PatternDepth = lpgc_pkg::PatternDepthDef,
  parameter int RingAddrBits = lpgc_pkg::RingAddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lpgc_pkg::CfgDataW-1:0] cfg_wdata_i,
  lpgc_in_if.sink                       in_i,
  lpgc_out_if.source                    out_o
);

  localparam int PAW = $clog2(PatternDepth);

  lpgc_pkg::lpgc_cfg_t  cfg;
  lpgc_pkg::lpgc_item_t s1_q;
  lpgc_pkg::lpgc_s1_t   s1_res;
  logic                 s1_valid_q;
  logic                 s2_ready, adv1, mem_busy;
  logic [PAW-1:0]       phase, wr_addr;
  logic                 wr_en;
  logic [7:0]           wr_data, rd_data;

  lpgc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  // Input register
  assign adv1       = s1_valid_q && s2_ready;
  assign in_i.ready = !mem_busy && (!s1_valid_q || s2_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || s2_ready) begin
      s1_valid_q <= in_i.valid && in_i.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.mode          <= in_i.mode;
      s1_q.data_in       <= in_i.data_in;
      s1_q.pattern_index <= in_i.pattern_index;
    end
  end

  lpgc_stream_ctr #(
    .PatternDepth (PatternDepth),
    .RingAddrBits (RingAddrBits)
  ) u_ctr (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg),
    .adv_i     (adv1),
    .item_i    (s1_q),
    .phase_o   (phase),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .res_o     (s1_res)
  );

  lpgc_pattern_mem #(
    .PatternDepth (PatternDepth)
  ) u_mem (
    .clk_i,
    .rst_ni,
    .rd_en_i   (adv1),
    .rd_addr_i (phase),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data),
    .busy_o    (mem_busy)
  );

  lpgc_check u_chk_stage (
    .clk_i,
    .rst_ni,
    .s1_valid_i (s1_valid_q),
    .s1_i       (s1_res),
    .s1_ready_o (s2_ready),
    .expect_i   (rd_data),
    .out_o
  );

endmodule

// ===== src/lpgc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lpgc_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module lpgc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lpgc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output lpgc_pkg::lpgc_cfg_t           cfg_o
);

  lpgc_pkg::lpgc_cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lpgc_pkg::CFG_RING_BYTES:   cfg_d.ring_bytes        = cfg_wdata_i;
        lpgc_pkg::CFG_TICK_BYTES:   cfg_d.tick_bytes        = cfg_wdata_i;
        lpgc_pkg::CFG_PERIOD_BYTES: cfg_d.period_size_bytes = cfg_wdata_i;
        lpgc_pkg::CFG_PAT_LEN:
          cfg_d.pattern_length = cfg_wdata_i[lpgc_pkg::PatLenW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_bytes        <= lpgc_pkg::RingBytesRst;
      cfg_q.tick_bytes        <= lpgc_pkg::TickBytesRst;
      cfg_q.period_size_bytes <= lpgc_pkg::PeriodBytesRst;
      cfg_q.pattern_length    <= lpgc_pkg::PatLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/lpgc_pattern_mem.sv =====
// ----------------------------------------------------------------------------
// lpgc_pattern_mem
// Pattern store: one write port, one registered read port, and a seeding
// pass after reset that writes the default pattern one entry per cycle.
// ----------------------------------------------------------------------------
module lpgc_pattern_mem #(
  parameter int PatternDepth = lpgc_pkg::PatternDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [$clog2(PatternDepth)-1:0] rd_addr_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(PatternDepth)-1:0] wr_addr_i,
  input  logic [7:0]                      wr_data_i,
  output logic [7:0]                      rd_data_o,
  output logic                            busy_o
);

  localparam int PAW = $clog2(PatternDepth);

  logic [7:0]     mem [PatternDepth];
  logic [PAW-1:0] seed_addr_q, seed_addr_d;
  logic           busy_q, busy_d;
  logic [7:0]     rd_data_q;

  // Step the seeding pass
  always_comb begin
    seed_addr_d = seed_addr_q;
    busy_d      = busy_q;
    if (busy_q) begin
      if (seed_addr_q == PAW'(PatternDepth - 1)) begin
        busy_d = 1'b0;
      end else begin
        seed_addr_d = seed_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_addr_q <= '0;
      busy_q      <= 1'b1;
    end else begin
      seed_addr_q <= seed_addr_d;
      busy_q      <= busy_d;
    end
  end

  // Write the seed, or a loaded byte
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[seed_addr_q] <= lpgc_pkg::seed_byte(lpgc_pkg::SeedIdxW'(seed_addr_q));
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

// ===== src/lpgc_stream_ctr.sv =====
// ----------------------------------------------------------------------------
// lpgc_stream_ctr
// Front stage: ring position, pattern phase, period and tick counters.
// Issues the pattern store read for the current phase and the load write.
// ----------------------------------------------------------------------------
module lpgc_stream_ctr #(
  parameter int PatternDepth = lpgc_pkg::PatternDepthDef,
  parameter int RingAddrBits = lpgc_pkg::RingAddrBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lpgc_pkg::lpgc_cfg_t             cfg_i,
  input  logic                            adv_i,
  input  lpgc_pkg::lpgc_item_t            item_i,
  output logic [$clog2(PatternDepth)-1:0] phase_o,
  output logic                            wr_en_o,
  output logic [$clog2(PatternDepth)-1:0] wr_addr_o,
  output logic [7:0]                      wr_data_o,
  output lpgc_pkg::lpgc_s1_t              res_o
);

  localparam int PAW = $clog2(PatternDepth);
  localparam int PLW = (PAW + 1 > lpgc_pkg::PatLenW) ? PAW + 1 : lpgc_pkg::PatLenW;
  localparam int RW  = (RingAddrBits + 1 > lpgc_pkg::CfgDataW) ?
                       RingAddrBits + 1 : lpgc_pkg::CfgDataW;
  localparam int BW  = lpgc_pkg::BlockCntW;
  localparam int CW  = lpgc_pkg::CfgDataW;
  localparam int IW  = lpgc_pkg::PatIdxW + 3;

  logic [RingAddrBits-1:0] ring_q, ring_d;
  logic [PAW-1:0]          phase_q, phase_d;
  logic [BW-1:0]           period_q, period_d;
  logic [BW-1:0]           tick_q, tick_d;
  logic                    pend_q, pend_d;

  logic [RW-1:0]  ring_full, ring_cfg, ring_lim, ring_inc;
  logic [PLW-1:0] pat_cfg, pat_lim, phase_inc;
  logic [CW-1:0]  period_lim, tick_lim, period_inc, tick_inc;
  logic           step, tick_end, period_el;

  // Clamp the limits
  always_comb begin
    ring_full = RW'(1) << RingAddrBits;
    ring_cfg  = RW'(cfg_i.ring_bytes);
    ring_lim  = (ring_cfg == '0 || ring_cfg > ring_full) ? ring_full : ring_cfg;
    pat_cfg   = PLW'(cfg_i.pattern_length);
    if (pat_cfg == '0) begin
      pat_lim = PLW'(1);
    end else if (pat_cfg > PLW'(PatternDepth)) begin
      pat_lim = PLW'(PatternDepth);
    end else begin
      pat_lim = pat_cfg;
    end
    period_lim = lpgc_pkg::block_lim(cfg_i.period_size_bytes);
    tick_lim   = lpgc_pkg::block_lim(cfg_i.tick_bytes);
  end

  assign ring_inc   = RW'(ring_q) + RW'(1);
  assign phase_inc  = PLW'(phase_q) + PLW'(1);
  assign period_inc = CW'(period_q) + CW'(1);
  assign tick_inc   = CW'(tick_q) + CW'(1);

  assign step = (item_i.mode == lpgc_pkg::MODE_PLAY) ||
                (item_i.mode == lpgc_pkg::MODE_CAPTURE);

  // Advance the counters for a playback or capture byte, clear on restart
  always_comb begin
    ring_d    = ring_q;
    phase_d   = phase_q;
    period_d  = period_q;
    tick_d    = tick_q;
    pend_d    = pend_q;
    tick_end  = 1'b0;
    period_el = 1'b0;
    if (step) begin
      ring_d  = (ring_inc >= ring_lim) ? '0 : ring_inc[RingAddrBits-1:0];
      phase_d = (phase_inc >= pat_lim) ? '0 : phase_inc[PAW-1:0];
      if (period_inc >= period_lim) begin
        period_d = '0;
        pend_d   = 1'b1;
      end else begin
        period_d = period_inc[BW-1:0];
      end
      if (tick_inc >= tick_lim) begin
        tick_end  = 1'b1;
        period_el = pend_d;
        pend_d    = 1'b0;
        tick_d    = '0;
      end else begin
        tick_d = tick_inc[BW-1:0];
      end
    end else if (item_i.mode == lpgc_pkg::MODE_RESTART) begin
      ring_d   = '0;
      phase_d  = '0;
      period_d = '0;
      tick_d   = '0;
      pend_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q   <= '0;
      phase_q  <= '0;
      period_q <= '0;
      tick_q   <= '0;
      pend_q   <= 1'b0;
    end else if (adv_i) begin
      ring_q   <= ring_d;
      phase_q  <= phase_d;
      period_q <= period_d;
      tick_q   <= tick_d;
      pend_q   <= pend_d;
    end
  end

  // Load write, dropped when the index is past the store
  assign wr_en_o   = adv_i && (item_i.mode == lpgc_pkg::MODE_LOAD) &&
                     (IW'(item_i.pattern_index) < IW'(PatternDepth));
  assign wr_addr_o = PAW'(item_i.pattern_index);
  assign wr_data_o = item_i.data_in;
  assign phase_o   = phase_q;

  // Hand the request on to the check stage
  always_comb begin
    res_o.mode           = item_i.mode;
    res_o.data           = item_i.data_in;
    res_o.addr           = (item_i.mode == lpgc_pkg::MODE_RESTART) ?
                           '0 : lpgc_pkg::RingOutW'(ring_q);
    res_o.tick_end       = tick_end;
    res_o.period_elapsed = period_el;
  end

endmodule

// ===== src/lpgc_check.sv =====
// ----------------------------------------------------------------------------
// lpgc_check
// Check stage: compares playback bytes with the pattern, keeps the skip and
// sticky mismatch flags, and holds the output register.
// ----------------------------------------------------------------------------
module lpgc_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  input  lpgc_pkg::lpgc_s1_t s1_i,
  output logic               s1_ready_o,
  input  logic [7:0]         expect_i,
  lpgc_out_if.source         out_o
);

  logic               s2_valid_q;
  lpgc_pkg::lpgc_s1_t s2_q;
  logic               out_valid_q;
  lpgc_pkg::lpgc_res_t out_q, res_d;
  logic               skip_q, skip_d, mism_q, mism_d;
  logic               out_en, s2_en, s2_fire;

  // Stage enables
  assign out_en     = !out_valid_q || out_o.ready;
  assign s2_en      = !s2_valid_q || out_en;
  assign s2_fire    = s2_valid_q && out_en;
  assign s1_ready_o = s2_en;

  // Compare and build the result
  always_comb begin
    skip_d = skip_q;
    mism_d = mism_q;
    res_d.data_out       = s2_q.data;
    res_d.ring_address   = s2_q.addr;
    res_d.period_elapsed = 1'b0;
    res_d.tick_end       = 1'b0;
    case (s2_q.mode)
      lpgc_pkg::MODE_LOAD: begin
        res_d.data_out = s2_q.data;
      end
      lpgc_pkg::MODE_RESTART: begin
        skip_d         = 1'b0;
        mism_d         = 1'b0;
        res_d.data_out = 8'd0;
      end
      default: begin
        res_d.data_out = expect_i;
        if (s2_q.mode == lpgc_pkg::MODE_PLAY && !mism_q && !skip_q) begin
          if (s2_q.data == 8'd0) begin
            skip_d = 1'b1;
          end else if (s2_q.data != expect_i) begin
            mism_d = 1'b1;
            skip_d = 1'b1;
          end
        end
        if (s2_q.tick_end) begin
          skip_d = 1'b0;
        end
        res_d.period_elapsed = s2_q.period_elapsed;
        res_d.tick_end       = s2_q.tick_end;
      end
    endcase
    res_d.mismatch_flag = mism_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      skip_q      <= 1'b0;
      mism_q      <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
      if (s2_fire) begin
        skip_q <= skip_d;
        mism_q <= mism_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_q <= s1_i;
    end
    if (s2_fire) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data_out       = out_q.data_out;
  assign out_o.ring_address   = out_q.ring_address;
  assign out_o.period_elapsed = out_q.period_elapsed;
  assign out_o.mismatch_flag  = out_q.mismatch_flag;
  assign out_o.tick_end       = out_q.tick_end;

endmodule

// ===== src/lpgc_checker.sv =====
// ----------------------------------------------------------------------------
// lpgc_checker
// Port-level checks of the looped pattern generator and checker.
// ----------------------------------------------------------------------------
module lpgc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_period_elapsed_i,
  input logic out_tick_end_i
);

  // Hold a stalled result
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Report a period only at the end of a tick
  a_period_on_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_period_elapsed_i |-> out_tick_end_i)
    else $error("period elapsed outside a tick end");

  // Show no result once reset has been seen at an edge
  a_rst_out : assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  // Take no request once reset has been seen at an edge
  a_rst_in : assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_i)
    else $error("request taken during reset");

endmodule

bind looped_pattern_generator_checker lpgc_checker u_lpgc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_period_elapsed_i (out_o.period_elapsed),
  .out_tick_end_i       (out_o.tick_end)
);
